// ===== rtl/aes_pkg.sv =====
// Package for the AES block cipher: payload and status types, the S-box tables
// and the round transforms. It depends on nothing; the top level imports it.
package aes_pkg;

  typedef struct packed {
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic        decrypt;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } aes_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_LOAD,
    ST_FIRST,
    ST_ROUND,
    ST_OUT
  } aes_state_t;

  localparam logic [2:0] REG_KEY_LENGTH = 3'd0;
  localparam logic [2:0] REG_KEY_WORD_0 = 3'd1;
  localparam logic [2:0] REG_KEY_WORD_3 = 3'd4;

  localparam logic [1:0] KEYLEN_128 = 2'd0;
  localparam logic [1:0] KEYLEN_192 = 2'd1;

  localparam int RK_DEPTH = 15;
  localparam int RK_AW    = 4;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // Multiply by x in GF(2^8) with the AES polynomial.
  function automatic logic [7:0] xtime(input logic [7:0] v);
    xtime = {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] v, input logic [3:0] k);
    logic [7:0] acc;
    logic [7:0] p;
    acc = 8'h00;
    p   = v;
    for (int b = 0; b < 4; b++) begin
      if (k[b]) acc = acc ^ p;
      p = xtime(p);
    end
    gmul = acc;
  endfunction

  // Byte i of the state sits in bits 127-8i down to 120-8i.
  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    for (int i = 0; i < 16; i++) begin
      o[8*i +: 8] = inv ? INV_SBOX[s[8*i +: 8]] : SBOX[s[8*i +: 8]];
    end
    sub_bytes = o;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    int src;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = inv ? ((c + 4 - r) % 4) : ((c + r) % 4);
        o[127 - 8*(r + 4*c) -: 8] = s[127 - 8*(r + 4*src) -: 8];
      end
    end
    shift_rows = o;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] o;
    logic [7:0] a, b, d, e, x;
    for (int c = 0; c < 4; c++) begin
      a = s[127 - 32*c -: 8];
      b = s[119 - 32*c -: 8];
      d = s[111 - 32*c -: 8];
      e = s[103 - 32*c -: 8];
      if (!inv) begin
        x = a ^ b ^ d ^ e;
        o[127 - 32*c -: 8] = a ^ x ^ xtime(a ^ b);
        o[119 - 32*c -: 8] = b ^ x ^ xtime(b ^ d);
        o[111 - 32*c -: 8] = d ^ x ^ xtime(d ^ e);
        o[103 - 32*c -: 8] = e ^ x ^ xtime(e ^ a);
      end else begin
        o[127 - 32*c -: 8] = gmul(a, 4'd14) ^ gmul(b, 4'd11) ^ gmul(d, 4'd13) ^ gmul(e, 4'd9);
        o[119 - 32*c -: 8] = gmul(a, 4'd9) ^ gmul(b, 4'd14) ^ gmul(d, 4'd11) ^ gmul(e, 4'd13);
        o[111 - 32*c -: 8] = gmul(a, 4'd13) ^ gmul(b, 4'd9) ^ gmul(d, 4'd14) ^ gmul(e, 4'd11);
        o[103 - 32*c -: 8] = gmul(a, 4'd11) ^ gmul(b, 4'd13) ^ gmul(d, 4'd9) ^ gmul(e, 4'd14);
      end
    end
    mix_columns = o;
  endfunction

endpackage

// ===== rtl/aes_block_cipher.sv =====
// AES block cipher top level: configuration registers, key expansion into
// the round key memories and the round datapath. Depends on aes_pkg.
// A block passes through load, first key and Nr rounds (Nr = 10, 12, 14) to the result;
// the first block after reset or a key length or key word write runs the key expansion first.
// One block is in work at a time (idle, load, first key, Nr rounds at one per cycle,
// result); a new block is taken only once the result has left without a stall.
// Reset (rst, synchronous) clears key registers and marks the keys as not expanded.
module aes_block_cipher
  import aes_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  aes_in_t        in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output aes_out_t       out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [2:0]     cfg_index,
  input  logic [63:0]    cfg_data
);

  // Configuration registers.
  logic [1:0]  key_length;
  logic [63:0] key_word [4];
  logic        keys_expanded;

  aes_state_t state, state_next;

  // Round key store: round r lives at address r, bytes 0..7 in the even memory
  // and bytes 8..15 in the odd memory, so one read fetches a whole round key.
  logic [63:0]      rk_even [RK_DEPTH];
  logic [63:0]      rk_odd  [RK_DEPTH];
  logic [RK_AW-1:0] rd_addr;
  logic [63:0]      rk_hi, rk_lo;

  // Key expansion: a window of the last eight words and a word counter.
  logic [31:0] hist [8];
  logic [31:0] prev_word;
  logic [5:0]  wi;
  logic [2:0]  col;
  logic [7:0]  rcon;
  logic [31:0] new_word;
  logic [31:0] tw;

  logic [3:0] nk, nr;
  logic [5:0] total_last;
  logic [2:0] nk_last;

  // Datapath.
  logic [127:0] st;
  logic [127:0] round_out;
  logic [127:0] tmp;
  logic         dec;
  logic [3:0]   cnt;
  logic         last_round;

  assign nk = (key_length == KEYLEN_128) ? 4'd4 : (key_length == KEYLEN_192) ? 4'd6 : 4'd8;
  assign nr = nk + 4'd6;
  assign nk_last = 3'(nk - 4'd1);
  assign total_last = {nk, 2'b00} + 6'd27;
  assign last_round = (cnt == nr);

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign out_data  = '{result_high: st[127:64], result_low: st[63:0]};

  // Next word of the key schedule. The first Nk words are the key itself.
  always_comb begin
    tw = hist[0];
    if (col == 3'd0) begin
      tw = sub_word({hist[0][23:0], hist[0][31:24]}) ^ {rcon, 24'h0};
    end else if (nk == 4'd8 && col == 3'd4) begin
      tw = sub_word(hist[0]);
    end
    if (wi < {2'b00, nk}) begin
      new_word = wi[0] ? key_word[wi[2:1]][31:0] : key_word[wi[2:1]][63:32];
    end else begin
      new_word = hist[nk_last] ^ tw;
    end
  end

  // One round. Encryption: SubBytes, ShiftRows, MixColumns (not in the last
  // round), AddRoundKey. Decryption follows the inverse order with the key
  // added before InvMixColumns.
  always_comb begin
    if (!dec) begin
      tmp = shift_rows(sub_bytes(st, 1'b0), 1'b0);
      if (!last_round) tmp = mix_columns(tmp, 1'b0);
      round_out = tmp ^ {rk_hi, rk_lo};
    end else begin
      tmp = sub_bytes(shift_rows(st, 1'b1), 1'b1) ^ {rk_hi, rk_lo};
      round_out = last_round ? tmp : mix_columns(tmp, 1'b1);
    end
  end

  // Next state and the round key read address, set in the cycle before the key is used.
  always_comb begin
    state_next = state;
    rd_addr    = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = keys_expanded ? ST_LOAD : ST_EXPAND;
      end
      ST_EXPAND: begin
        if (wi == total_last) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        rd_addr    = dec ? nr : 4'd0;
        state_next = ST_FIRST;
      end
      ST_FIRST: begin
        rd_addr    = dec ? (nr - 4'd1) : 4'd1;
        state_next = ST_ROUND;
      end
      ST_ROUND: begin
        if (last_round) begin
          state_next = ST_OUT;
        end else begin
          rd_addr = dec ? (nr - cnt - 4'd1) : (cnt + 4'd1);
        end
      end
      ST_OUT: begin
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Configuration writes; any write to a listed register forces a new expansion.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_length    <= KEYLEN_128;
      keys_expanded <= 1'b0;
      for (int k = 0; k < 4; k++) key_word[k] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_KEY_LENGTH) begin
          key_length    <= cfg_data[1:0];
          keys_expanded <= 1'b0;
        end else if (cfg_index inside {[REG_KEY_WORD_0:REG_KEY_WORD_3]}) begin
          key_word[2'(cfg_index - REG_KEY_WORD_0)] <= cfg_data;
          keys_expanded <= 1'b0;
        end
      end
      if (state == ST_EXPAND && wi == total_last) keys_expanded <= 1'b1;
    end
  end

  // Round key memories: synchronous read, written two words at a time.
  always_ff @(posedge clk) begin
    rk_hi <= rk_even[rd_addr];
    rk_lo <= rk_odd[rd_addr];
    if (state == ST_EXPAND && wi[0]) begin
      if (!wi[1]) rk_even[wi[5:2]] <= {prev_word, new_word};
      else        rk_odd[wi[5:2]]  <= {prev_word, new_word};
    end
  end

  // Key schedule registers and the block state.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        wi   <= '0;
        col  <= '0;
        rcon <= 8'h01;
        if (in_valid) begin
          st  <= {in_data.block_high, in_data.block_low};
          dec <= in_data.decrypt;
        end
      end
      ST_EXPAND: begin
        prev_word <= new_word;
        hist[0]   <= new_word;
        for (int k = 1; k < 8; k++) hist[k] <= hist[k-1];
        wi  <= wi + 6'd1;
        col <= (col == nk_last) ? 3'd0 : col + 3'd1;
        if (wi >= {2'b00, nk} && col == 3'd0) rcon <= xtime(rcon);
      end
      ST_FIRST: begin
        st  <= st ^ {rk_hi, rk_lo};
        cnt <= 4'd1;
      end
      ST_ROUND: begin
        st  <= round_out;
        cnt <= cnt + 4'd1;
      end
      default: ;
    endcase
  end

endmodule

// ===== verif/aes_checker.sv =====
// Scoreboard for the AES block cipher: watches the block, key and result
// channels, computes the expected cipher output and compares. Uses aes_pkg types.
module aes_checker
  import aes_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_stall,
  input  aes_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  aes_out_t out_data,
  input  logic     cfg_valid,
  input  logic     cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output int       errors,
  output int       pending
);

  localparam logic [7:0] S_TAB [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  logic [1:0]  klen;
  logic [63:0] kword [4];
  logic [7:0]  rkey [240];
  logic [7:0]  inv_tab [256];
  bit          expanded;
  aes_out_t    expected_blocks [$];

  function automatic logic [7:0] dbl(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] mul(input logic [7:0] v, input int k);
    logic [7:0] acc;
    acc = 0;
    while (k != 0) begin
      if (k & 1) acc ^= v;
      v = dbl(v);
      k >>= 1;
    end
    return acc;
  endfunction

  function automatic int words_in_key();
    return (klen == KEYLEN_128) ? 4 : (klen == KEYLEN_192) ? 6 : 8;
  endfunction

  task automatic expand_schedule();
    int nk, total;
    logic [7:0] t [4];
    logic [7:0] t0, rc;
    nk = words_in_key();
    total = 4 * (nk + 7);
    rc = 8'h01;
    for (int i = 0; i < 4 * nk; i++) rkey[i] = kword[i / 8][63 - 8 * (i % 8) -: 8];
    for (int i = nk; i < total; i++) begin
      for (int b = 0; b < 4; b++) t[b] = rkey[4 * (i - 1) + b];
      if (i % nk == 0) begin
        t0 = t[0];
        t[0] = S_TAB[t[1]] ^ rc;
        t[1] = S_TAB[t[2]];
        t[2] = S_TAB[t[3]];
        t[3] = S_TAB[t0];
        rc = dbl(rc);
      end else if (nk > 6 && i % nk == 4) begin
        for (int b = 0; b < 4; b++) t[b] = S_TAB[t[b]];
      end
      for (int b = 0; b < 4; b++) rkey[4 * i + b] = rkey[4 * (i - nk) + b] ^ t[b];
    end
    expanded = 1;
  endtask

  function automatic aes_out_t cipher_block(input aes_in_t blk);
    logic [7:0] s [16];
    logic [7:0] o [16];
    logic [7:0] a, b, d, e, x;
    int nr, src;
    aes_out_t res;
    nr = words_in_key() + 6;
    for (int i = 0; i < 16; i++)
      s[i] = (i < 8) ? blk.block_high[63 - 8 * i -: 8] : blk.block_low[63 - 8 * (i - 8) -: 8];
    for (int step = 0; step <= nr; step++) begin
      int r;
      r = blk.decrypt ? nr - step : step;
      if (step > 0) begin
        o = s;
        for (int c = 0; c < 4; c++)
          for (int q = 0; q < 4; q++) begin
            src = blk.decrypt ? (c + 4 - q) % 4 : (c + q) % 4;
            s[q + 4 * c] = blk.decrypt ? inv_tab[o[q + 4 * src]] : S_TAB[o[q + 4 * src]];
          end
        if (!blk.decrypt && step < nr)
          for (int c = 0; c < 4; c++) begin
            a = s[4*c]; b = s[4*c+1]; d = s[4*c+2]; e = s[4*c+3];
            x = a ^ b ^ d ^ e;
            s[4*c]   ^= x ^ dbl(a ^ b);
            s[4*c+1] ^= x ^ dbl(b ^ d);
            s[4*c+2] ^= x ^ dbl(d ^ e);
            s[4*c+3] ^= x ^ dbl(e ^ a);
          end
      end
      for (int i = 0; i < 16; i++) s[i] ^= rkey[16 * r + i];
      // Decryption applies the inverse column mix after the key in the middle rounds.
      if (blk.decrypt && step > 0 && step < nr)
        for (int c = 0; c < 4; c++) begin
          a = s[4*c]; b = s[4*c+1]; d = s[4*c+2]; e = s[4*c+3];
          s[4*c]   = mul(a, 14) ^ mul(b, 11) ^ mul(d, 13) ^ mul(e, 9);
          s[4*c+1] = mul(a, 9) ^ mul(b, 14) ^ mul(d, 11) ^ mul(e, 13);
          s[4*c+2] = mul(a, 13) ^ mul(b, 9) ^ mul(d, 14) ^ mul(e, 11);
          s[4*c+3] = mul(a, 11) ^ mul(b, 13) ^ mul(d, 9) ^ mul(e, 14);
        end
    end
    for (int i = 0; i < 8; i++) begin
      res.result_high[63 - 8 * i -: 8] = s[i];
      res.result_low[63 - 8 * i -: 8] = s[i + 8];
    end
    return res;
  endfunction

  initial begin
    for (int i = 0; i < 256; i++) inv_tab[S_TAB[i]] = i[7:0];
  end

  assign pending = expected_blocks.size();

  always @(posedge clk) begin
    aes_out_t want;
    if (rst) begin
      klen = KEYLEN_128;
      for (int i = 0; i < 4; i++) kword[i] = '0;
      expanded = 0;
      errors <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          errors <= errors + 1;
        end else begin
          want = expected_blocks.pop_front();
          if (want.result_high !== out_data.result_high ||
              want.result_low !== out_data.result_low) begin
            $display("%0t: result mismatch expected %h_%h actual %h_%h", $time,
                     want.result_high, want.result_low,
                     out_data.result_high, out_data.result_low);
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (!expanded) expand_schedule();
        expected_blocks.push_back(cipher_block(in_data));
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_KEY_LENGTH) begin
          klen = cfg_data[1:0];
          expanded = 0;
        end else if (cfg_index inside {[REG_KEY_WORD_0:REG_KEY_WORD_3]}) begin
          kword[2'(cfg_index - REG_KEY_WORD_0)] = cfg_data;
          expanded = 0;
        end
      end
    end
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the AES block cipher testbench: clock, reset, key setup, block
// stimulus and verdict. Depends on aes_pkg, aes_block_cipher and aes_checker.
module testbench;
  import aes_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 80;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  aes_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  aes_out_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int errors, pending;
  int cycle_count = 0;
  // When set, neither side idles; used for a burst at full rate.
  bit no_idle = 0;

  aes_block_cipher uut (.*);

  aes_checker scoreboard (.*);

  always #5 clk = ~clk;

  // The run is bounded so that a hung handshake still gives a verdict.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // The result side stalls at random, except during the burst stretch.
  always @(posedge clk) out_stall <= !no_idle && ($urandom_range(99) < 23);

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // One register write; the block is idle whenever this is called. The valid
  // is left high so that writes can follow each other; the caller drops it.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Stop offering blocks, wait for every outstanding result, then let the
  // pipeline settle.
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_key(input logic [1:0] len, input logic [63:0] k0, input logic [63:0] k1,
                          input logic [63:0] k2, input logic [63:0] k3);
    drain();
    write_reg(REG_KEY_LENGTH, {62'd0, len});
    write_reg(REG_KEY_WORD_0, k0);
    write_reg(REG_KEY_WORD_0 + 3'd1, k1);
    write_reg(REG_KEY_WORD_0 + 3'd2, k2);
    write_reg(REG_KEY_WORD_3, k3);
    cfg_valid <= 0;
  endtask

  // Offer one block; the valid stays high until a transfer takes place and is
  // left high afterwards, so the next block or a drain decides what follows.
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo, input logic dec);
    while (!no_idle && $urandom_range(99) < 23) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= '{block_high: hi, block_low: lo, decrypt: dec};
    do @(posedge clk); while (in_stall);
  endtask

  task automatic random_blocks(input int count);
    int pick;
    logic [63:0] hi, lo;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(9);
      hi = (pick == 0) ? '0 : (pick == 1) ? '1 : rand64();
      lo = (pick == 2) ? '0 : (pick == 3) ? '1 : rand64();
      send_block(hi, lo, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed part: the standard example vectors for each key size, both
    // directions, plus extreme blocks and key words.
    load_key(2'd0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, '1);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 0);
    send_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1);
    send_block('0, '0, 0);
    send_block('1, '1, 1);
    load_key(2'd1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617, '1);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 0);
    send_block(64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191, 1);
    send_block('1, '0, 0);
    load_key(2'd2, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, 64'h18191a1b1c1d1e1f);
    send_block(64'h0011223344556677, 64'h8899aabbccddeeff, 0);
    send_block(64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1);
    send_block('0, '1, 1);
    // The unused length code behaves as a 256-bit key.
    load_key(2'd3, '1, '1, '1, '1);
    send_block('0, '0, 0);
    send_block('1, '1, 1);
    load_key(2'd0, '0, '0, '0, '0);
    send_block('0, '0, 0);
    send_block('1, '1, 1);
    // A write to an index past the register list changes nothing.
    drain();
    write_reg(3'd7, rand64());
    cfg_valid <= 0;
    send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 0);

    // Random part: a new random key every so often, lengths chosen at random.
    for (int phase = 0; phase < 18; phase++) begin
      load_key(2'($urandom_range(3)), rand64(), rand64(), rand64(), rand64());
      if (phase == 5) no_idle = 1;
      if (phase == 7) no_idle = 0;
      random_blocks(50);
      // Mid-phase hold-off until every result has come back.
      in_valid <= 0;
      @(posedge clk);
      while (pending != 0) @(posedge clk);
      random_blocks(50);
    end

    drain();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== aes_block_cipher.f =====
rtl/aes_pkg.sv
rtl/aes_block_cipher.sv
verif/aes_checker.sv
verif/testbench.sv
